FILE: hdl/nrv_pkg.sv
// ----------------------------------------------------------------------------
// nrv_pkg
// Shared types and constants for the NRV stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none
package nrv_pkg;
    localparam int unsigned OutDepth = 65536;
    localparam logic [31:0] Low31    = 32'h7fffffff;
    localparam logic [31:0] AllOnes  = 32'hffffffff;
    localparam logic [31:0] Near2b   = 32'hfffff300;
    localparam logic [31:0] Near2de  = 32'hfffffb00;

    typedef enum logic [2:0] {
        ST_BYTE  = 3'd0,
        ST_NEED  = 3'd1,
        ST_DONE  = 3'd2,
        ST_EXH   = 3'd3,
        ST_BOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_VARIANT = 2'd0,
        CFG_SRCLEN  = 2'd1,
        CFG_CAP     = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data;
        logic [16:0] pos;
    } t_result;
endpackage
`default_nettype wire

FILE: hdl/nrv_ram.sv
// ----------------------------------------------------------------------------
// nrv_ram
// Generic single-port write, single-port registered-read RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module nrv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/nrv_bitstream_decompressor_top.sv
// ----------------------------------------------------------------------------
// nrv_bitstream_decompressor_top
// NRV 2B/2D/2E decompressor: bit sequencer over a history RAM.
// ----------------------------------------------------------------------------
// channel  | dir | fields
// s_axis   | in  | tuser=kind, tdata=source_byte
// m_axis   | out | tdata={out_position,data_out,status} (low to high: status)
// cfg      | in  | variant_mode, source_length, output_capacity
// One transfer in gives exactly one transfer out. The sequencer consumes one
// control bit per cycle in S_RUN; a copy byte reads the history RAM in S_RD.
// Synchronous active-low reset; RAM content is not cleared. Output register
// holds a result until taken; input is held off until then.
// ----------------------------------------------------------------------------
`default_nettype none
module nrv_bitstream_decompressor_top #(
    parameter int unsigned OUT_DEPTH = nrv_pkg::OutDepth
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // source_byte
    input  wire         s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // status[2:0], data_out[10:3], out_position[27:11]
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [24:0] i_cfg_data
);
    localparam int unsigned AW = $clog2(OUT_DEPTH);
    localparam int unsigned PW = AW + 1;

    // phases
    typedef enum logic [3:0] {
        PH_FLAG, PH_OFF_A, PH_OFF_B, PH_OFF_C, PH_CARRY, PH_L2D_B, PH_GAM_A,
        PH_GAM_B, PH_L2E_A, PH_L2E_C, PH_LIT, PH_OFF_BYTE, PH_COPY, PH_DONE,
        PH_EXH, PH_BOUND
    } t_phase;
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_RD, S_OUT} t_seq;

    logic [1:0]  r_variant;
    logic [24:0] r_srclen;
    logic [16:0] r_cap;
    t_seq        r_seq, n_seq;
    t_phase      r_ph, n_ph;
    logic [31:0] r_res, n_res, r_asm, n_asm, r_last, n_last, r_acc, n_acc;
    logic [31:0] r_len, n_len;
    logic [24:0] r_scnt, n_scnt;
    logic [PW-1:0] r_wpos, n_wpos;
    logic [2:0]  r_wb, n_wb;
    logic        r_held, n_held, r_hbit, n_hbit;
    logic        r_ovalid, n_ovalid;
    nrv_pkg::t_result r_out, n_out;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  wdata, rdata;

    nrv_ram #(.WIDTH(8), .DEPTH(OUT_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic is2b, is2e, src_left, cap_hit, bit_ok, bit_v;
    logic [PW-1:0] cap_lim;
    logic [31:0] mag, near;

    assign is2b = (r_variant == 2'd0);
    assign is2e = r_variant[1];
    assign src_left = r_scnt < r_srclen;
    assign cap_lim = ({8'd0, r_cap} > 25'(OUT_DEPTH)) ? PW'(OUT_DEPTH) : PW'(r_cap);
    assign cap_hit = {{(32-PW){1'b0}}, r_wpos} >= {{(32-PW){1'b0}}, cap_lim};
    assign mag = 32'd0 - r_last;
    assign near = is2b ? nrv_pkg::Near2b : nrv_pkg::Near2de;
    assign s_axis_tready = (r_seq == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {4'd0, r_out.pos, r_out.data, r_out.status};
    assign raddr = AW'(r_wpos - mag[PW-1:0]);

    always_comb begin
        logic [31:0] t;
        logic [31:0] fl;
        logic        rdy;
        n_seq = r_seq; n_ph = r_ph; n_res = r_res; n_asm = r_asm; n_last = r_last;
        n_acc = r_acc; n_len = r_len; n_scnt = r_scnt; n_wpos = r_wpos; n_wb = r_wb;
        n_held = r_held; n_hbit = r_hbit; n_ovalid = r_ovalid; n_out = r_out;
        we = 1'b0; waddr = r_wpos[AW-1:0]; wdata = s_axis_tdata;
        bit_ok = 1'b0; bit_v = 1'b0; t = '0; rdy = 1'b0;
        fl = r_len + ((r_last < near) ? 32'd1 : 32'd0) + (is2e ? 32'd2 : 32'd1);
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        unique case (r_seq)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_seq = S_RUN;
                    if (!s_axis_tuser) begin
                        if (r_ph == PH_LIT) begin
                            if (!src_left) n_ph = PH_EXH;
                            else if (cap_hit) n_ph = PH_BOUND;
                            else begin
                                n_scnt = r_scnt + 25'd1;
                                we = 1'b1;
                                n_wpos = r_wpos + PW'(1);
                                n_ph = PH_FLAG;
                                n_out = '{status: nrv_pkg::ST_BYTE, data: s_axis_tdata,
                                          pos: 17'(r_wpos + PW'(1))};
                                n_seq = S_OUT;
                            end
                        end else if (r_ph == PH_OFF_BYTE) begin
                            if (!src_left) n_ph = PH_EXH;
                            else begin
                                n_scnt = r_scnt + 25'd1;
                                t = ((r_acc << 8) + {24'd0, s_axis_tdata}) ^ nrv_pkg::AllOnes;
                                n_acc = t;
                                if (t == 32'd0) n_ph = PH_DONE;
                                else if (is2b) begin
                                    n_last = t; n_len = '0; n_ph = PH_CARRY;
                                end else begin
                                    n_len = {31'd0, t[0]};
                                    n_last = {t[31], t[31:1]};
                                    n_ph = is2e ? PH_L2E_A : PH_L2D_B;
                                end
                            end
                        end else if (r_ph <= PH_L2E_C && !r_held
                                     && (r_res & nrv_pkg::Low31) == '0) begin
                            if (!src_left) n_ph = PH_EXH;
                            else begin
                                n_scnt = r_scnt + 25'd1;
                                t = (r_wb == 3'd0) ? {24'd0, s_axis_tdata}
                                  : r_asm | ({24'd0, s_axis_tdata} << {r_wb[1:0], 3'd0});
                                n_asm = t;
                                if (r_wb == 3'd3) begin
                                    n_res = {t[30:0], 1'b1};
                                    n_hbit = t[31]; n_held = 1'b1; n_wb = 3'd0;
                                end else n_wb = r_wb + 3'd1;
                            end
                        end
                    end
                end
            end
            S_RUN: begin
                unique case (r_ph)
                    PH_DONE: begin
                        n_out = '{status: nrv_pkg::ST_DONE, data: 8'd0, pos: 17'(r_wpos)};
                        n_seq = S_OUT;
                    end
                    PH_EXH: begin
                        n_out = '{status: nrv_pkg::ST_EXH, data: 8'd0, pos: 17'(r_wpos)};
                        n_seq = S_OUT;
                    end
                    PH_BOUND: begin
                        n_out = '{status: nrv_pkg::ST_BOUND, data: 8'd0, pos: 17'(r_wpos)};
                        n_seq = S_OUT;
                    end
                    PH_LIT, PH_OFF_BYTE: begin
                        if (!src_left) n_ph = PH_EXH;
                        else if (r_ph == PH_LIT && cap_hit) n_ph = PH_BOUND;
                        else begin
                            n_out = '{status: nrv_pkg::ST_NEED, data: 8'd0,
                                      pos: 17'(r_wpos)};
                            n_seq = S_OUT;
                        end
                    end
                    PH_COPY: begin
                        if (r_len == '0) n_ph = PH_FLAG;
                        else if (cap_hit || !r_last[31]) n_ph = PH_BOUND;
                        else if (mag > {{(32-PW){1'b0}}, r_wpos}) n_ph = PH_BOUND;
                        else n_seq = S_RD;
                    end
                    default: begin
                        if (r_held) begin
                            bit_ok = 1'b1; bit_v = r_hbit; n_held = 1'b0;
                        end else if ((r_res & nrv_pkg::Low31) != '0) begin
                            bit_ok = 1'b1; bit_v = r_res[31]; n_res = r_res << 1;
                        end else if (r_wb == 3'd0 && (r_scnt > r_srclen
                                     || r_srclen - r_scnt < 25'd4)) begin
                            n_ph = PH_EXH;
                        end else begin
                            n_out = '{status: nrv_pkg::ST_NEED, data: 8'd0,
                                      pos: 17'(r_wpos)};
                            n_seq = S_OUT;
                        end
                        if (bit_ok) begin
                            unique case (r_ph)
                                PH_FLAG: begin
                                    if (bit_v) n_ph = PH_LIT;
                                    else begin n_acc = 32'd1; n_ph = PH_OFF_A; end
                                end
                                PH_OFF_A, PH_OFF_C: begin
                                    n_acc = {r_acc[30:0], bit_v};
                                    n_ph = (r_ph == PH_OFF_A) ? PH_OFF_B : PH_OFF_A;
                                end
                                PH_OFF_B: begin
                                    if (bit_v) begin
                                        t = r_acc - 32'd3; n_acc = t;
                                        if (!t[31]) n_ph = PH_OFF_BYTE;
                                        else begin n_len = '0; n_ph = PH_CARRY; end
                                    end else if (is2b) n_ph = PH_OFF_A;
                                    else begin n_acc = r_acc - 32'd1; n_ph = PH_OFF_C; end
                                end
                                PH_CARRY: begin
                                    n_len = {31'd0, bit_v};
                                    n_ph = is2e ? PH_L2E_A : PH_L2D_B;
                                end
                                PH_L2D_B: begin
                                    t = {r_len[30:0], bit_v};
                                    if (t == '0) begin n_len = 32'd1; n_ph = PH_GAM_A; end
                                    else begin
                                        n_len = t + ((r_last < near) ? 32'd1 : 32'd0)
                                              + (is2e ? 32'd2 : 32'd1);
                                        n_ph = PH_COPY;
                                    end
                                end
                                PH_GAM_A: begin
                                    n_len = {r_len[30:0], bit_v}; n_ph = PH_GAM_B;
                                end
                                PH_GAM_B: begin
                                    if (bit_v) begin n_len = fl + 32'd2; n_ph = PH_COPY; end
                                    else n_ph = PH_GAM_A;
                                end
                                PH_L2E_A: begin
                                    if (r_len != '0) begin
                                        n_len = {31'd0, bit_v}
                                              + ((r_last < near) ? 32'd1 : 32'd0)
                                              + (is2e ? 32'd2 : 32'd1);
                                        n_ph = PH_COPY;
                                    end else if (bit_v) n_ph = PH_L2E_C;
                                    else begin n_len = 32'd1; n_ph = PH_GAM_A; end
                                end
                                default: begin
                                    n_len = 32'd2 + {31'd0, bit_v}
                                          + ((r_last < near) ? 32'd1 : 32'd0)
                                          + (is2e ? 32'd2 : 32'd1);
                                    n_ph = PH_COPY;
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_RD: n_seq = S_RUN;  // wait for RAM read; copy taken below
            S_OUT: begin
                rdy = !r_ovalid || m_axis_tready;
                if (rdy) begin
                    n_ovalid = 1'b1;
                    n_seq = S_IDLE;
                end
            end
            default: n_seq = S_IDLE;
        endcase
        // copy byte written from S_RD, using read data registered from the S_RUN address
        if (r_seq == S_RD) begin
            n_seq = S_OUT;
            we = 1'b1;
            wdata = rdata;
            n_wpos = r_wpos + PW'(1);
            n_len = r_len - 32'd1;
            if (r_len == 32'd1) n_ph = PH_FLAG;
            n_out = '{status: nrv_pkg::ST_BYTE, data: rdata, pos: 17'(r_wpos + PW'(1))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= '0; r_srclen <= '0; r_cap <= 17'd65536;
            r_seq <= S_IDLE; r_ph <= PH_FLAG; r_res <= '0; r_asm <= '0;
            r_last <= nrv_pkg::AllOnes; r_acc <= '0; r_len <= '0; r_scnt <= '0;
            r_wpos <= '0; r_wb <= '0; r_held <= 1'b0; r_hbit <= 1'b0;
            r_ovalid <= 1'b0; r_out <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (nrv_pkg::t_cfg_idx'(i_cfg_idx))
                    nrv_pkg::CFG_VARIANT: r_variant <= i_cfg_data[1:0];
                    nrv_pkg::CFG_SRCLEN:  r_srclen <= i_cfg_data;
                    nrv_pkg::CFG_CAP:     r_cap <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            r_seq <= n_seq; r_ph <= n_ph; r_res <= n_res; r_asm <= n_asm;
            r_last <= n_last; r_acc <= n_acc; r_len <= n_len; r_scnt <= n_scnt;
            r_wpos <= n_wpos; r_wb <= n_wb; r_held <= n_held; r_hbit <= n_hbit;
            r_ovalid <= n_ovalid; r_out <= n_out;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/nrv_checker.sv
// ----------------------------------------------------------------------------
// nrv_checker
// Port-level checks for the NRV decompressor.
// ----------------------------------------------------------------------------
`default_nettype none
module nrv_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer dropped");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
        else $error("bad status");
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[10:3] == 8'd0)
        else $error("data on non-byte status");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted while busy");
endmodule

bind nrv_bitstream_decompressor_top nrv_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

FILE: verif/tb_nrv_bitstream_decompressor_top.sv
// ----------------------------------------------------------------------------
// tb_nrv_bitstream_decompressor_top
// Self-checking bench for the NRV 2B/2D/2E decompressor. A cycle-free
// decoder model predicts every output transfer. Control words are planned
// against a copy of that model, so matches stay inside the written history
// and the stream runs deep through all variants. The run ends by starving
// the source and checking that the error status sticks.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_nrv_bitstream_decompressor_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HW = $clog2(nrv_pkg::OutDepth);

    typedef enum logic [4:0] {
        PH_FLAG, PH_OFF_A, PH_OFF_B, PH_OFF_C, PH_CARRY, PH_L2D_B, PH_GAM_A,
        PH_GAM_B, PH_L2E_A, PH_L2E_C, PH_LIT, PH_OFF_BYTE, PH_COPY, PH_DONE,
        PH_EXH, PH_BOUND
    } t_phase;

    typedef struct {
        t_phase      ph;
        logic [31:0] acc;
        logic [31:0] len;
        logic [31:0] lo;
        logic [31:0] wp;
    } t_decoder;

    typedef struct packed {
        logic             kind;
        logic [7:0]       val;
        logic             typed;
        nrv_pkg::t_status st;
        logic [7:0]       data;
        logic [16:0]      pos;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // source_byte
    logic        s_axis_tuser = 1'b0; // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // status, data_out, out_position
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [24:0] i_cfg_data = '0;

    nrv_bitstream_decompressor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    logic [1:0]  variant;
    logic [24:0] srclen;
    logic [16:0] cap;
    t_decoder    dec;
    logic [31:0] reserve;
    logic [31:0] word_acc;
    logic [31:0] src_cnt;
    int          word_bytes;
    logic        held_bit;
    logic        bit_held;
    logic [7:0]  history [0:nrv_pkg::OutDepth-1];

    nrv_pkg::t_result expected_q [$];
    logic [7:0]  word_q [$];
    logic [7:0]  offset_q [$];
    nrv_pkg::t_status last_st;
    nrv_pkg::t_result got;
    int          n_items = 0;
    int          errs = 0;
    int          s_idle = 14;
    int          r_idle = 73;

    function automatic void finish_len(inout t_decoder d);
        if (d.lo < ((variant == 2'd0) ? nrv_pkg::Near2b : nrv_pkg::Near2de)) d.len += 1;
        d.len += (variant >= 2'd2) ? 32'd2 : 32'd1;
        d.ph = PH_COPY;
    endfunction

    function automatic void decode_bit(inout t_decoder d, input logic b);
        case (d.ph)
            PH_FLAG: begin
                if (b) d.ph = PH_LIT;
                else begin
                    d.acc = 32'd1;
                    d.ph = PH_OFF_A;
                end
            end
            PH_OFF_A: begin
                d.acc = d.acc * 2 + {31'b0, b};
                d.ph = PH_OFF_B;
            end
            PH_OFF_B: begin
                if (b) begin
                    d.acc -= 3;
                    if (!d.acc[31]) d.ph = PH_OFF_BYTE;
                    else begin
                        d.len = '0;
                        d.ph = PH_CARRY;
                    end
                end else if (variant == 2'd0) begin
                    d.ph = PH_OFF_A;
                end else begin
                    d.acc -= 1;
                    d.ph = PH_OFF_C;
                end
            end
            PH_OFF_C: begin
                d.acc = d.acc * 2 + {31'b0, b};
                d.ph = PH_OFF_A;
            end
            PH_CARRY: begin
                d.len = {31'b0, b};
                if (variant >= 2'd2) d.ph = PH_L2E_A;
                else d.ph = PH_L2D_B;
            end
            PH_L2D_B: begin
                d.len = d.len * 2 + {31'b0, b};
                if (d.len == 0) begin
                    d.len = 32'd1;
                    d.ph = PH_GAM_A;
                end else finish_len(d);
            end
            PH_GAM_A: begin
                d.len = d.len * 2 + {31'b0, b};
                d.ph = PH_GAM_B;
            end
            PH_GAM_B: begin
                if (b) begin
                    d.len += 2;
                    finish_len(d);
                end else d.ph = PH_GAM_A;
            end
            PH_L2E_A: begin
                if (d.len != 0) begin
                    d.len = {31'b0, b};
                    finish_len(d);
                end else if (b) d.ph = PH_L2E_C;
                else begin
                    d.len = 32'd1;
                    d.ph = PH_GAM_A;
                end
            end
            default: begin
                d.len = 32'd2 + {31'b0, b};
                finish_len(d);
            end
        endcase
    endfunction

    function automatic void decode_offset_byte(inout t_decoder d, input logic [7:0] v);
        logic [31:0] a;
        a = ((d.acc << 8) + {24'b0, v}) ^ nrv_pkg::AllOnes;
        d.acc = a;
        if (a == 0) d.ph = PH_DONE;
        else if (variant == 2'd0) begin
            d.lo = a;
            d.len = '0;
            d.ph = PH_CARRY;
        end else begin
            d.len = {31'b0, a[0]};
            d.lo = (a >> 1) | (a & 32'h80000000);
            if (variant >= 2'd2) d.ph = PH_L2E_A;
            else d.ph = PH_L2D_B;
        end
    endfunction

    function automatic logic [31:0] cap_limit();
        return (cap > nrv_pkg::OutDepth) ? nrv_pkg::OutDepth : {15'b0, cap};
    endfunction

    function automatic nrv_pkg::t_result make_result(nrv_pkg::t_status s, logic [7:0] v);
        nrv_pkg::t_result r;
        r.status = s;
        r.data = v;
        r.pos = dec.wp[16:0];
        return r;
    endfunction

    function automatic nrv_pkg::t_result run_decoder();
        logic [31:0] mag;
        logic [7:0]  c;
        repeat (4096) begin
            case (dec.ph)
                PH_DONE:  return make_result(nrv_pkg::ST_DONE, 8'd0);
                PH_EXH:   return make_result(nrv_pkg::ST_EXH, 8'd0);
                PH_BOUND: return make_result(nrv_pkg::ST_BOUND, 8'd0);
                PH_LIT: begin
                    if (src_cnt >= {7'b0, srclen}) dec.ph = PH_EXH;
                    else if (dec.wp >= cap_limit()) dec.ph = PH_BOUND;
                    else return make_result(nrv_pkg::ST_NEED, 8'd0);
                end
                PH_OFF_BYTE: begin
                    if (src_cnt >= {7'b0, srclen}) dec.ph = PH_EXH;
                    else return make_result(nrv_pkg::ST_NEED, 8'd0);
                end
                PH_COPY: begin
                    mag = 32'd0 - dec.lo;
                    if (dec.len == 0) dec.ph = PH_FLAG;
                    else if (dec.wp >= cap_limit() || !dec.lo[31] || mag > dec.wp)
                        dec.ph = PH_BOUND;
                    else begin
                        c = history[HW'(dec.wp - mag)];
                        history[HW'(dec.wp)] = c;
                        dec.wp++;
                        dec.len--;
                        if (dec.len == 0) dec.ph = PH_FLAG;
                        return make_result(nrv_pkg::ST_BYTE, c);
                    end
                end
                default: begin
                    if (bit_held) begin
                        bit_held = 1'b0;
                        decode_bit(dec, held_bit);
                    end else if ((reserve & nrv_pkg::Low31) != 0) begin
                        c[0] = reserve[31];
                        reserve = reserve << 1;
                        decode_bit(dec, c[0]);
                    end else if (word_bytes == 0 && (src_cnt > {7'b0, srclen} ||
                                 {7'b0, srclen} - src_cnt < 4)) begin
                        dec.ph = PH_EXH;
                    end else return make_result(nrv_pkg::ST_NEED, 8'd0);
                end
            endcase
        end
        return make_result(nrv_pkg::ST_BOUND, 8'd0);
    endfunction

    function automatic nrv_pkg::t_result decompress_step(logic kind, logic [7:0] v);
        nrv_pkg::t_result r;
        if (!kind) begin
            if (dec.ph == PH_LIT) begin
                if (src_cnt >= {7'b0, srclen}) dec.ph = PH_EXH;
                else if (dec.wp >= cap_limit()) dec.ph = PH_BOUND;
                else begin
                    src_cnt++;
                    history[HW'(dec.wp)] = v;
                    r = make_result(nrv_pkg::ST_BYTE, v);
                    r.pos = r.pos + 17'd1;
                    dec.wp++;
                    dec.ph = PH_FLAG;
                    return r;
                end
            end else if (dec.ph == PH_OFF_BYTE) begin
                if (src_cnt >= {7'b0, srclen}) dec.ph = PH_EXH;
                else begin
                    src_cnt++;
                    decode_offset_byte(dec, v);
                end
            end else if (dec.ph <= PH_L2E_C && !bit_held
                         && (reserve & nrv_pkg::Low31) == 0) begin
                if (src_cnt >= {7'b0, srclen}) dec.ph = PH_EXH;
                else begin
                    src_cnt++;
                    if (word_bytes == 0) word_acc = {24'b0, v};
                    else word_acc |= {24'b0, v} << (8 * word_bytes);
                    word_bytes++;
                    if (word_bytes >= 4) begin
                        reserve = {word_acc[30:0], 1'b1};
                        held_bit = word_acc[31];
                        bit_held = 1'b1;
                        word_bytes = 0;
                    end
                end
            end
        end
        return run_decoder();
    endfunction

    function automatic logic byte_awaited();
        return dec.ph == PH_LIT || dec.ph == PH_OFF_BYTE ||
               (dec.ph <= PH_L2E_C && !bit_held && (reserve & nrv_pkg::Low31) == 0);
    endfunction

    // a match whose offset high part is oa must be able to point into history
    function automatic logic offset_fits(logic [31:0] oa, logic [31:0] wp);
        logic [31:0] h;
        logic [31:0] mag;
        h = oa - 3;
        if (h[31]) return 1'b1;
        mag = (variant == 2'd0) ? (h << 8) + 1 : ((h << 8) >> 1) + 1;
        return mag <= wp;
    endfunction

    function automatic logic pick_bit(t_decoder d);
        logic b;
        b = 1'($urandom_range(0, 1));
        case (d.ph)
            PH_FLAG:  b = (d.wp == 0) || ($urandom_range(0, 99) < 55);
            PH_OFF_A: if (b && !offset_fits(d.acc * 2 + 1, d.wp)) b = 1'b0;
            PH_OFF_B: b = (d.acc > 512) || ($urandom_range(0, 99) < 60) ||
                          !offset_fits((variant == 2'd0) ? d.acc * 2 : (d.acc - 1) * 4, d.wp);
            PH_OFF_C: if (b && !offset_fits((d.acc * 2 + 1) * 2, d.wp)) b = 1'b0;
            PH_GAM_B: b = (d.len > 8) || ($urandom_range(0, 99) < 60);
            default: ;
        endcase
        return b;
    endfunction

    // build one control word whose tokens stay legal; queue its offset bytes
    function automatic logic [31:0] plan_control_word();
        t_decoder    d;
        t_decoder    t;
        logic [31:0] w;
        logic [7:0]  v;
        logic        b;
        d = dec;
        for (int i = 31; i >= 0; i--) begin
            b = pick_bit(d);
            w[i] = b;
            decode_bit(d, b);
            while (d.ph == PH_LIT || d.ph == PH_OFF_BYTE || d.ph == PH_COPY) begin
                if (d.ph == PH_LIT) begin
                    d.wp++;
                    d.ph = PH_FLAG;
                end else if (d.ph == PH_OFF_BYTE) begin
                    v = 8'($urandom_range(0, 255));
                    t = d;
                    decode_offset_byte(t, v);
                    if (t.ph == PH_DONE || !t.lo[31] || (32'd0 - t.lo) > d.wp) v = 8'd0;
                    offset_q.push_back(v);
                    decode_offset_byte(d, v);
                end else begin
                    d.wp += d.len;
                    d.ph = PH_FLAG;
                end
            end
        end
        return w;
    endfunction

    task automatic cfg_write(nrv_pkg::t_cfg_idx idx, logic [24:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            nrv_pkg::CFG_VARIANT: variant = data[1:0];
            nrv_pkg::CFG_SRCLEN:  srclen = data;
            default:              cap = data[16:0];
        endcase
    endtask

    task automatic send(logic kind, logic [7:0] v);
        while ($urandom_range(0, 99) < s_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_items++;
        if (n_items == 400) begin
            s_idle = 73;
            r_idle = 14;
        end else if (n_items == 800) begin
            s_idle = 0;
            r_idle = 0;
        end
    endtask

    task automatic issue_next();
        logic        kind;
        logic [7:0]  v;
        logic [31:0] w;
        nrv_pkg::t_result r;
        kind = 1'b1;
        v = 8'($urandom_range(0, 255));
        if (last_st == nrv_pkg::ST_NEED) begin
            if ($urandom_range(0, 99) >= 5) begin
                kind = 1'b0;
                if (dec.ph == PH_OFF_BYTE) begin
                    if (offset_q.size() != 0) v = offset_q.pop_front();
                end else if (dec.ph != PH_LIT) begin
                    if (word_q.size() == 0) begin
                        w = plan_control_word();
                        for (int i = 0; i < 4; i++) word_q.push_back(w[8*i +: 8]);
                    end
                    v = word_q.pop_front();
                end
            end
        end else if (last_st == nrv_pkg::ST_BYTE) begin
            if ($urandom_range(0, 99) < 6 && !byte_awaited()) kind = 1'b0;
        end else begin
            kind = 1'($urandom_range(0, 1));
        end
        r = decompress_step(kind, v);
        last_st = nrv_pkg::t_status'(r.status);
        expected_q.push_back(r);
        send(kind, v);
    endtask

    function automatic logic at_word_edge();
        return dec.ph == PH_FLAG && !bit_held && (reserve & nrv_pkg::Low31) == 0 &&
               word_bytes == 0 && last_st == nrv_pkg::ST_NEED;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                errs++;
                if (errs <= 10) $display("unexpected transfer: %h", m_axis_tdata);
            end else begin
                got = expected_q.pop_front();
                if (m_axis_tdata[2:0] != got.status || m_axis_tdata[10:3] != got.data ||
                    m_axis_tdata[27:11] != got.pos) begin
                    errs++;
                    if (errs <= 10)
                        $display("mismatch: exp st=%0d data=%h pos=%0d, got st=%0d data=%h pos=%0d",
                                 got.status, got.data, got.pos, m_axis_tdata[2:0],
                                 m_axis_tdata[10:3], m_axis_tdata[27:11]);
                end
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= r_idle);
    end

    t_dir_row dir_tab [15] = '{
        '{1'b1, 8'h00, 1'b1, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b0, 8'hff, 1'b1, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b0, 8'hff, 1'b1, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b0, 8'hff, 1'b1, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b0, 8'hff, 1'b1, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b1, 8'h5a, 1'b1, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b0, 8'h00, 1'b1, nrv_pkg::ST_BYTE, 8'h00, 17'd1},
        '{1'b1, 8'hff, 1'b1, nrv_pkg::ST_NEED, 8'h00, 17'd1},
        '{1'b0, 8'hff, 1'b1, nrv_pkg::ST_BYTE, 8'hff, 17'd2},
        '{1'b1, 8'h00, 1'b1, nrv_pkg::ST_NEED, 8'h00, 17'd2},
        '{1'b0, 8'h80, 1'b1, nrv_pkg::ST_BYTE, 8'h80, 17'd3},
        '{1'b0, 8'h33, 1'b0, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b1, 8'h00, 1'b0, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b0, 8'h01, 1'b0, nrv_pkg::ST_NEED, 8'h00, 17'd0},
        '{1'b0, 8'h7f, 1'b0, nrv_pkg::ST_NEED, 8'h00, 17'd0}
    };

    initial begin
        nrv_pkg::t_result r;
        int      guard;
        variant = 2'd0;
        srclen = '0;
        cap = 17'h10000;
        dec = '{PH_FLAG, 32'd0, 32'd0, nrv_pkg::AllOnes, 32'd0};
        reserve = '0;
        word_acc = '0;
        src_cnt = '0;
        word_bytes = 0;
        held_bit = 1'b0;
        bit_held = 1'b0;
        last_st = nrv_pkg::ST_NEED;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_write(nrv_pkg::CFG_VARIANT, 25'd0);
        cfg_write(nrv_pkg::CFG_SRCLEN, 25'h1000000);
        cfg_write(nrv_pkg::CFG_CAP, 25'h10000);

        foreach (dir_tab[i]) begin
            r = decompress_step(dir_tab[i].kind, dir_tab[i].val);
            last_st = nrv_pkg::t_status'(r.status);
            if (dir_tab[i].typed) begin
                r.status = dir_tab[i].st;
                r.data = dir_tab[i].data;
                r.pos = dir_tab[i].pos;
            end
            expected_q.push_back(r);
            send(dir_tab[i].kind, dir_tab[i].val);
        end

        for (int p = 0; p < 4; p++) begin
            if (p > 0) begin
                guard = 0;
                while (!at_word_edge() && dec.ph < PH_DONE && guard < 2000) begin
                    issue_next();
                    guard++;
                end
                drain();
                cfg_write(nrv_pkg::CFG_VARIANT, 25'(p));
                if (p == 2) cfg_write(nrv_pkg::CFG_CAP, 25'd60000);
                if (p == 3) begin
                    cfg_write(nrv_pkg::CFG_SRCLEN, src_cnt[24:0] + 25'd200000);
                    cfg_write(nrv_pkg::CFG_CAP, 25'h10000);
                end
            end
            repeat (270) issue_next();
        end

        guard = 0;
        while (!at_word_edge() && dec.ph < PH_DONE && guard < 2000) begin
            issue_next();
            guard++;
        end
        drain();
        cfg_write(nrv_pkg::CFG_SRCLEN, src_cnt[24:0] + 25'($urandom_range(0, 40)));
        guard = 0;
        while (dec.ph < PH_DONE && guard < 2000) begin
            issue_next();
            guard++;
        end
        repeat (20) issue_next();
        drain();
        cfg_write(nrv_pkg::CFG_CAP, 25'd1);
        cfg_write(nrv_pkg::CFG_SRCLEN, 25'd0);
        repeat (10) issue_next();

        drain();
        repeat (50) @(posedge i_clk);
        if (errs == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
